// ===== design/ccs_pkg.sv =====
package ccs_pkg;

   // corner slots, in output order
   localparam int CORNERS        = 4;
   localparam int CORNER_SUM_MAX  = 0;
   localparam int CORNER_DIFF_MAX = 1;
   localparam int CORNER_SUM_MIN  = 2;
   localparam int CORNER_RDIFF_MAX = 3;

   // angle format
   localparam int ANGLE_BITS      = 16;
   localparam int ANGLE_FRAC_BITS = 14;
   localparam int ACC_FRAC        = 30;
   localparam int RND_SHIFT       = ACC_FRAC - ANGLE_FRAC_BITS;

   // cordic datapath
   localparam int CORDIC_STEPS = 30;
   localparam int STEP_BITS    = 5;
   localparam int VEC_W        = 46;
   localparam int ZW           = 33;
   localparam int NORM_SHIFT   = 40;
   localparam logic signed [ZW-1:0] HALF_PI_Q30 = 33'sd1686629713;

   // status of the angle unit seen by the top level
   typedef struct packed {
      logic busy;
      logic done;
   } unit_status_type;

   // atan(2^-i) in Q30, truncated
   function automatic logic signed [ZW-1:0] atan_entry(input logic [STEP_BITS-1:0] idx);
      logic signed [ZW-1:0] val;
      case (idx)
         5'd0: val = 33'sd843314856;
         5'd1: val = 33'sd497837829;
         5'd2: val = 33'sd263043836;
         5'd3: val = 33'sd133525158;
         5'd4: val = 33'sd67021686;
         5'd5: val = 33'sd33543515;
         5'd6: val = 33'sd16775850;
         5'd7: val = 33'sd8388437;
         5'd8: val = 33'sd4194282;
         5'd9: val = 33'sd2097149;
         default: val = (ZW'(1) << (STEP_BITS'(ACC_FRAC) - idx)) - ZW'(1);
      endcase
      return val;
   endfunction

endpackage

// ===== design/ccs_corners.sv =====
module ccs_corners #(
   parameter int COORD_BITS = 12
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         take,
   input  logic [COORD_BITS-1:0]        pt_x,
   input  logic [COORD_BITS-1:0]        pt_y,
   input  logic                         last_point,
   output logic [COORD_BITS-1:0]        corner_x [ccs_pkg::CORNERS],
   output logic [COORD_BITS-1:0]        corner_y [ccs_pkg::CORNERS],
   output logic signed [COORD_BITS:0]   top_dx,
   output logic signed [COORD_BITS:0]   top_dy,
   output logic signed [COORD_BITS:0]   bot_dx,
   output logic signed [COORD_BITS:0]   bot_dy
);
   import ccs_pkg::*;

   logic [COORD_BITS-1:0] cx_ff [CORNERS];
   logic [COORD_BITS-1:0] cy_ff [CORNERS];
   logic [COORD_BITS-1:0] cx_in [CORNERS];
   logic [COORD_BITS-1:0] cy_in [CORNERS];
   logic                  first_ff, first_in;

   logic [COORD_BITS:0] px, py;
   logic [COORD_BITS:0] cx [CORNERS];
   logic [COORD_BITS:0] cy [CORNERS];
   logic [CORNERS-1:0]  beat;

   // zero-extended copies for the compares
   always_comb begin
      px = {1'b0, pt_x};
      py = {1'b0, pt_y};
      for (int k = 0; k < CORNERS; k++) begin
         cx[k] = {1'b0, cx_ff[k]};
         cy[k] = {1'b0, cy_ff[k]};
      end
   end

   // strict compares keep the earliest point on ties; differences moved across
   always_comb begin
      beat[CORNER_SUM_MAX]   = (px + py) > (cx[CORNER_SUM_MAX] + cy[CORNER_SUM_MAX]);
      beat[CORNER_DIFF_MAX]  = (px + cy[CORNER_DIFF_MAX]) > (cx[CORNER_DIFF_MAX] + py);
      beat[CORNER_SUM_MIN]   = (px + py) < (cx[CORNER_SUM_MIN] + cy[CORNER_SUM_MIN]);
      beat[CORNER_RDIFF_MAX] = (py + cx[CORNER_RDIFF_MAX]) > (cy[CORNER_RDIFF_MAX] + px);
   end

   // corner update; first point of a contour seeds all four
   always_comb begin
      first_in = first_ff;
      for (int k = 0; k < CORNERS; k++) begin
         cx_in[k] = cx_ff[k];
         cy_in[k] = cy_ff[k];
      end
      if (take) begin
         first_in = last_point;
         for (int k = 0; k < CORNERS; k++) begin
            if (first_ff || beat[k]) begin
               cx_in[k] = pt_x;
               cy_in[k] = pt_y;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_ff <= 1'b1;
         for (int k = 0; k < CORNERS; k++) begin
            cx_ff[k] <= '0;
            cy_ff[k] <= '0;
         end
      end else begin
         first_ff <= first_in;
         for (int k = 0; k < CORNERS; k++) begin
            cx_ff[k] <= cx_in[k];
            cy_ff[k] <= cy_in[k];
         end
      end
   end

   // edge vectors: top = sum_max - rdiff_max, bottom = diff_max - sum_min
   assign top_dx = $signed(cx[CORNER_SUM_MAX]) - $signed(cx[CORNER_RDIFF_MAX]);
   assign top_dy = $signed(cy[CORNER_SUM_MAX]) - $signed(cy[CORNER_RDIFF_MAX]);
   assign bot_dx = $signed(cx[CORNER_DIFF_MAX]) - $signed(cx[CORNER_SUM_MIN]);
   assign bot_dy = $signed(cy[CORNER_DIFF_MAX]) - $signed(cy[CORNER_SUM_MIN]);

   assign corner_x = cx_ff;
   assign corner_y = cy_ff;

endmodule

// ===== design/ccs_cordic.sv =====
module ccs_cordic #(
   parameter int COORD_BITS = 12
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   input  logic                                   ack,
   input  logic signed [COORD_BITS:0]             top_dx,
   input  logic signed [COORD_BITS:0]             top_dy,
   input  logic signed [COORD_BITS:0]             bot_dx,
   input  logic signed [COORD_BITS:0]             bot_dy,
   output ccs_pkg::unit_status_type               status,
   output logic signed [ccs_pkg::ANGLE_BITS-1:0]  angle,
   output logic                                   vertical
);
   import ccs_pkg::*;

   localparam int PROD_W = 2 * COORD_BITS + 2;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_MUL_A = 3'd1;
   localparam logic [2:0] ST_MUL_B = 3'd2;
   localparam logic [2:0] ST_MUL_C = 3'd3;
   localparam logic [2:0] ST_FIX   = 3'd4;
   localparam logic [2:0] ST_NORM  = 3'd5;
   localparam logic [2:0] ST_ITER  = 3'd6;
   localparam logic [2:0] ST_DONE  = 3'd7;

   localparam logic signed [VEC_W-1:0] NORM_POS = VEC_W'(1) << NORM_SHIFT;
   localparam logic signed [VEC_W-1:0] NORM_NEG = -NORM_POS;
   localparam logic [STEP_BITS-1:0]    LAST_STEP = STEP_BITS'(CORDIC_STEPS - 1);
   localparam logic signed [ZW:0]      RND_HALF = (ZW + 1)'(1) << (RND_SHIFT - 1);
   localparam logic signed [ZW:0]      SAT_POS = (ZW + 1)'(32767);
   localparam logic signed [ZW:0]      SAT_NEG = -(ZW + 1)'(32768);

   logic [2:0]                 state_ff, state_in;
   logic signed [COORD_BITS:0] tx_ff, ty_ff, bx_ff, by_ff;
   logic signed [COORD_BITS:0] tx_in, ty_in, bx_in, by_in;
   logic signed [VEC_W-1:0]    vx_ff, vy_ff, vx_in, vy_in;
   logic signed [ZW-1:0]       z_ff, z_in;
   logic [STEP_BITS-1:0]       step_ff, step_in;
   logic                       vert_ff, vert_in;

   logic signed [COORD_BITS:0] mul_a, mul_b;
   logic signed [PROD_W-1:0]   prod;
   logic signed [VEC_W-1:0]    prod_ext;
   logic signed [VEC_W-1:0]    xs, ys;
   logic                       fits, y_pos;
   logic signed [ZW:0]         rnd_sum, rnd_q;

   // shared multiplier: ty*bx, by*tx, then tx*bx
   always_comb begin
      case (state_ff)
         ST_MUL_A: begin
            mul_a = ty_ff;
            mul_b = bx_ff;
         end
         ST_MUL_B: begin
            mul_a = by_ff;
            mul_b = tx_ff;
         end
         default: begin
            mul_a = tx_ff;
            mul_b = bx_ff;
         end
      endcase
      prod     = PROD_W'(mul_a) * PROD_W'(mul_b);
      prod_ext = {{(VEC_W - PROD_W){prod[PROD_W-1]}}, prod};
   end

   // shift unit and vector tests
   always_comb begin
      xs    = vx_ff >>> step_ff;
      ys    = vy_ff >>> step_ff;
      fits  = (vx_ff < NORM_POS) && (vy_ff < NORM_POS) && (vy_ff > NORM_NEG);
      y_pos = !vy_ff[VEC_W-1] && (vy_ff != '0);
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      tx_in    = tx_ff;
      ty_in    = ty_ff;
      bx_in    = bx_ff;
      by_in    = by_ff;
      vx_in    = vx_ff;
      vy_in    = vy_ff;
      z_in     = z_ff;
      step_in  = step_ff;
      vert_in  = vert_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               tx_in   = top_dx;
               ty_in   = top_dy;
               bx_in   = bot_dx;
               by_in   = bot_dy;
               vert_in = (top_dx == '0) || (bot_dx == '0);
               if ((top_dx == '0) || (bot_dx == '0)) begin
                  z_in     = HALF_PI_Q30;
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_MUL_A;
               end
            end
         end
         ST_MUL_A: begin
            vy_in    = prod_ext;
            state_in = ST_MUL_B;
         end
         ST_MUL_B: begin
            vy_in    = vy_ff + prod_ext;
            state_in = ST_MUL_C;
         end
         ST_MUL_C: begin
            vx_in    = prod_ext <<< 1;
            state_in = ST_FIX;
         end
         ST_FIX: begin
            // move the vector into the right half plane
            if (vx_ff[VEC_W-1]) begin
               vx_in = -vx_ff;
               vy_in = -vy_ff;
            end
            state_in = ST_NORM;
         end
         ST_NORM: begin
            if (fits) begin
               vx_in = vx_ff <<< 1;
               vy_in = vy_ff <<< 1;
            end else begin
               z_in     = '0;
               step_in  = '0;
               state_in = ST_ITER;
            end
         end
         ST_ITER: begin
            if (y_pos) begin
               vx_in = vx_ff + ys;
               vy_in = vy_ff - xs;
               z_in  = z_ff + atan_entry(step_ff);
            end else begin
               vx_in = vx_ff - ys;
               vy_in = vy_ff + xs;
               z_in  = z_ff - atan_entry(step_ff);
            end
            step_in = step_ff + STEP_BITS'(1);
            if (step_ff == LAST_STEP) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (ack) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      tx_ff   <= tx_in;
      ty_ff   <= ty_in;
      bx_ff   <= bx_in;
      by_ff   <= by_in;
      vx_ff   <= vx_in;
      vy_ff   <= vy_in;
      z_ff    <= z_in;
      step_ff <= step_in;
      vert_ff <= vert_in;
   end

   // round half up to the output format, then saturate
   always_comb begin
      rnd_sum = {z_ff[ZW-1], z_ff} + RND_HALF;
      rnd_q   = rnd_sum >>> RND_SHIFT;
      if (rnd_q > SAT_POS) begin
         angle = ANGLE_BITS'(SAT_POS);
      end else if (rnd_q < SAT_NEG) begin
         angle = ANGLE_BITS'(SAT_NEG);
      end else begin
         angle = ANGLE_BITS'(rnd_q);
      end
   end

   assign vertical    = vert_ff;
   assign status.busy = (state_ff != ST_IDLE);
   assign status.done = (state_ff == ST_DONE);

   // checks
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> state_ff == ST_IDLE)
      else $error("angle unit started while busy");

   a_ack_done: assert property (@(posedge clock) disable iff (reset)
      ack |-> state_ff == ST_DONE)
      else $error("result taken before angle unit finished");

   a_step_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_ITER |-> step_ff <= LAST_STEP)
      else $error("rotation count out of range");

   a_x_positive: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_ITER |-> !vx_ff[VEC_W-1] && vx_ff != '0)
      else $error("rotation vector left the right half plane");

endmodule

// ===== design/contour_corner_skew.sv =====
// Channel  Direction  Handshake           Payload
// req      in         req_valid/req_stall pt_x, pt_y, last_point
// rsp      out        rsp_valid/rsp_stall skew_angle, vertical, four corners (x, y)
//
// A point that is not last does not raise req_stall; points stream at one per cycle
// while req_stall is low. After a last point, req_stall stays high while the shared
// multiply/shift/rotate unit runs: the start flag, three products and sign fix,
// normalizing doublings (16 to 39) and a step to leave them, 30 rotation steps and
// the hand-off; a vertical edge goes from start straight to hand-off.
// The result sits in an output register, so a new contour can stream in while
// rsp is stalled; a second result waits in the angle unit until rsp is free.
// Synchronous active-high reset clears the sequencer, handshake flags and corners.
module contour_corner_skew #(
   parameter int COORD_BITS = 12
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic [COORD_BITS-1:0]                  req_pt_x,
   input  logic [COORD_BITS-1:0]                  req_pt_y,
   input  logic                                   req_last_point,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [ccs_pkg::ANGLE_BITS-1:0]  rsp_skew_angle,
   output logic                                   rsp_vertical,
   output logic [COORD_BITS-1:0]                  rsp_sum_max_x,
   output logic [COORD_BITS-1:0]                  rsp_sum_max_y,
   output logic [COORD_BITS-1:0]                  rsp_diff_max_x,
   output logic [COORD_BITS-1:0]                  rsp_diff_max_y,
   output logic [COORD_BITS-1:0]                  rsp_sum_min_x,
   output logic [COORD_BITS-1:0]                  rsp_sum_min_y,
   output logic [COORD_BITS-1:0]                  rsp_rdiff_max_x,
   output logic [COORD_BITS-1:0]                  rsp_rdiff_max_y
);
   import ccs_pkg::*;

   logic                       take;
   logic                       start_ff, start_in;
   logic                       out_load;
   unit_status_type            status;
   logic [COORD_BITS-1:0]      corner_x [CORNERS];
   logic [COORD_BITS-1:0]      corner_y [CORNERS];
   logic signed [COORD_BITS:0] top_dx, top_dy, bot_dx, bot_dy;
   logic signed [ANGLE_BITS-1:0] angle;
   logic                       vertical;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [ANGLE_BITS-1:0] angle_ff;
   logic                       vert_ff;
   logic [COORD_BITS-1:0]      ox_ff [CORNERS];
   logic [COORD_BITS-1:0]      oy_ff [CORNERS];

   // input transfer; held off while an angle is in progress
   assign req_stall = start_ff | status.busy;
   assign take      = req_valid & ~req_stall;
   assign start_in  = take & req_last_point;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff <= 1'b0;
      end else begin
         start_ff <= start_in;
      end
   end

   ccs_corners #(.COORD_BITS(COORD_BITS)) u_corners (
      .clock      (clock),
      .reset      (reset),
      .take       (take),
      .pt_x       (req_pt_x),
      .pt_y       (req_pt_y),
      .last_point (req_last_point),
      .corner_x   (corner_x),
      .corner_y   (corner_y),
      .top_dx     (top_dx),
      .top_dy     (top_dy),
      .bot_dx     (bot_dx),
      .bot_dy     (bot_dy)
   );

   ccs_cordic #(.COORD_BITS(COORD_BITS)) u_cordic (
      .clock    (clock),
      .reset    (reset),
      .start    (start_ff),
      .ack      (out_load),
      .top_dx   (top_dx),
      .top_dy   (top_dy),
      .bot_dx   (bot_dx),
      .bot_dy   (bot_dy),
      .status   (status),
      .angle    (angle),
      .vertical (vertical)
   );

   // output register; corners are still intact while the unit is busy
   assign out_load = status.done & (~rsp_valid_ff | ~rsp_stall);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         angle_ff <= angle;
         vert_ff  <= vertical;
         ox_ff    <= corner_x;
         oy_ff    <= corner_y;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_skew_angle  = angle_ff;
   assign rsp_vertical    = vert_ff;
   assign rsp_sum_max_x   = ox_ff[CORNER_SUM_MAX];
   assign rsp_sum_max_y   = oy_ff[CORNER_SUM_MAX];
   assign rsp_diff_max_x  = ox_ff[CORNER_DIFF_MAX];
   assign rsp_diff_max_y  = oy_ff[CORNER_DIFF_MAX];
   assign rsp_sum_min_x   = ox_ff[CORNER_SUM_MIN];
   assign rsp_sum_min_y   = oy_ff[CORNER_SUM_MIN];
   assign rsp_rdiff_max_x = ox_ff[CORNER_RDIFF_MAX];
   assign rsp_rdiff_max_y = oy_ff[CORNER_RDIFF_MAX];

endmodule
